/* rtl/fdsr_pkg.sv */
// shared constants and digit-to-segment lookup for the four-digit segment readout
`default_nettype none

package fdsr_pkg;

	localparam int unsigned InTdataWidth  = 24;
	localparam int unsigned OutTdataWidth = 32;

	localparam logic [7:0] SegBlank = 8'h00;
	localparam logic [7:0] SegDash  = 8'h04;
	localparam logic [7:0] SegL     = 8'h0B;
	localparam logic [7:0] SegLowO  = 8'h27;
	localparam logic [7:0] SegH     = 8'h6E;
	localparam logic [7:0] SegI     = 8'h0A;
	localparam logic [7:0] SegZero  = 8'hEB;
	localparam logic [7:0] MarkBit  = 8'h10;

	// reciprocal factors for divide by 10 and by 100, exact for values below 2000
	localparam logic [12:0] RecipTen     = 13'd6554;
	localparam int unsigned RecipTenSh   = 16;
	localparam logic [12:0] RecipHundred = 13'd5243;
	localparam int unsigned RecipHundSh  = 19;

	function automatic logic [7:0] digit_seg(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'hEB;
			4'd1: s = 8'h60;
			4'd2: s = 8'hC7;
			4'd3: s = 8'hE5;
			4'd4: s = 8'h6C;
			4'd5: s = 8'hAD;
			4'd6: s = 8'hAF;
			4'd7: s = 8'hE0;
			4'd8: s = 8'hEF;
			4'd9: s = 8'hED;
			default: s = SegBlank;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/four_digit_segment_readout_top.sv */
// top level: signed reading to 3.5-digit seven-segment bytes, input and result registers
// Takes one reading per cycle while s_tready is high into the input register and
// presents its segment bytes from the result register on m_tdata, held there while
// m_tready is low; throughput is one transaction per cycle while m_tready stays high,
// set by the single decode pass between the input register and the result register.
// s_tready drops only while both registers are full and m_tready is low.
`default_nettype none

module four_digit_segment_readout_top (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// value[15:0], point_on[16], battery_mark[17], hold_mark[18], zero fill
	input  wire logic [fdsr_pkg::InTdataWidth-1:0]       s_tdata,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// leading_one[0], hundreds_segments[8:1], tens_segments[16:9],
	// units_segments[24:17], zero fill
	output logic [fdsr_pkg::OutTdataWidth-1:0]           m_tdata
);

	logic               valid_s1;
	logic signed [15:0] value_s1;
	logic               point_s1;
	logic               battery_s1;
	logic               hold_s1;

	logic               valid_s2;
	logic               one_s2;
	logic [7:0]         hund_s2;
	logic [7:0]         tens_s2;
	logic [7:0]         units_s2;

	logic               adv_s2;
	logic               adv_s1;

	logic               is_lo;
	logic               is_hi;
	logic               is_neg;
	logic [15:0]        abs_w;
	logic [10:0]        mag;
	logic [23:0]        prod_ten;
	logic [23:0]        prod_hund;
	logic [7:0]         q_ten;
	logic [4:0]         q_hund;
	logic [10:0]        units_w;
	logic [7:0]         tens_w;
	logic [3:0]         hund_d;
	logic [7:0]         seg_u;
	logic [7:0]         seg_t;
	logic [7:0]         seg_h;
	logic               one_d;
	logic [7:0]         hund_d_seg;
	logic [7:0]         tens_d_seg;
	logic [7:0]         units_d_seg;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			value_s1   <= s_tdata[15:0];
			point_s1   <= s_tdata[16];
			battery_s1 <= s_tdata[17];
			hold_s1    <= s_tdata[18];
		end
	end

	// classify and take apart into decimal digits
	assign is_lo  = value_s1 < -16'sd99;
	assign is_hi  = value_s1 > 16'sd1999;
	assign is_neg = value_s1[15];
	assign abs_w  = is_neg ? (~value_s1 + 16'd1) : value_s1;
	assign mag    = abs_w[10:0];

	assign prod_ten  = 24'(mag) * 24'(fdsr_pkg::RecipTen);
	assign prod_hund = 24'(mag) * 24'(fdsr_pkg::RecipHundred);
	assign q_ten     = prod_ten[fdsr_pkg::RecipTenSh +: 8];
	assign q_hund    = prod_hund[fdsr_pkg::RecipHundSh +: 5];
	assign units_w   = mag - 11'(q_ten) * 11'd10;
	assign tens_w    = q_ten - 8'(q_hund) * 8'd10;
	assign hund_d    = (q_hund >= 5'd10) ? 4'(q_hund - 5'd10) : q_hund[3:0];

	assign seg_u = fdsr_pkg::digit_seg(units_w[3:0]);
	assign seg_t = fdsr_pkg::digit_seg(tens_w[3:0]);
	assign seg_h = fdsr_pkg::digit_seg(hund_d);

	always_comb begin
		one_d       = 1'b0;
		hund_d_seg  = fdsr_pkg::SegBlank;
		tens_d_seg  = fdsr_pkg::SegBlank;
		units_d_seg = seg_u;
		if (is_lo) begin
			tens_d_seg  = fdsr_pkg::SegL;
			units_d_seg = fdsr_pkg::SegLowO;
		end else if (is_hi) begin
			tens_d_seg  = fdsr_pkg::SegH;
			units_d_seg = fdsr_pkg::SegI;
		end else if (is_neg) begin
			if (mag >= 11'd10) begin
				hund_d_seg = fdsr_pkg::SegDash;
				tens_d_seg = seg_t;
			end else if (point_s1) begin
				hund_d_seg = fdsr_pkg::SegDash;
				tens_d_seg = fdsr_pkg::SegZero;
			end else begin
				tens_d_seg = fdsr_pkg::SegDash;
			end
		end else if (mag < 11'd10) begin
			tens_d_seg = point_s1 ? fdsr_pkg::SegZero : fdsr_pkg::SegBlank;
		end else if (mag < 11'd100) begin
			tens_d_seg = seg_t;
		end else begin
			one_d      = mag >= 11'd1000;
			hund_d_seg = seg_h;
			tens_d_seg = seg_t;
		end
		if (battery_s1) begin
			hund_d_seg = hund_d_seg | fdsr_pkg::MarkBit;
		end
		if (point_s1) begin
			tens_d_seg = tens_d_seg | fdsr_pkg::MarkBit;
		end
		if (hold_s1) begin
			units_d_seg = units_d_seg | fdsr_pkg::MarkBit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			one_s2   <= one_d;
			hund_s2  <= hund_d_seg;
			tens_s2  <= tens_d_seg;
			units_s2 <= units_d_seg;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, units_s2, tens_s2, hund_s2, one_s2};

endmodule

`default_nettype wire

/* verif/four_digit_segment_readout_checker.sv */
// checker: predicts segment bytes for each accepted reading and compares result transactions
`timescale 1ns / 1ps

module four_digit_segment_readout_checker (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	input  wire logic                                    s_tready,
	// value[15:0], point_on[16], battery_mark[17], hold_mark[18], zero fill
	input  wire logic [fdsr_pkg::InTdataWidth-1:0]       s_tdata,
	input  wire logic                                    m_tvalid,
	input  wire logic                                    m_tready,
	// leading_one[0], hundreds_segments[8:1], tens_segments[16:9],
	// units_segments[24:17], zero fill
	input  wire logic [fdsr_pkg::OutTdataWidth-1:0]      m_tdata,
	output int unsigned                                  pending,
	output int unsigned                                  fail_count
);

	typedef struct packed {
		logic       leading_one;
		logic [7:0] hundreds;
		logic [7:0] tens;
		logic [7:0] units;
	} readout_t;

	localparam logic [7:0] GlyphBlank = 8'h00;
	localparam logic [7:0] GlyphDash  = 8'h04;
	localparam logic [7:0] GlyphL     = 8'h0B;
	localparam logic [7:0] GlyphLowO  = 8'h27;
	localparam logic [7:0] GlyphH     = 8'h6E;
	localparam logic [7:0] GlyphI     = 8'h0A;
	localparam logic [7:0] Annunciator = 8'h10;

	// digits 9 down to 0, digit 0 in the lowest byte
	localparam logic [79:0] DigitGlyphs = {
		8'hED, 8'hEF, 8'hE0, 8'hAF, 8'hAD, 8'h6C, 8'hE5, 8'hC7, 8'h60, 8'hEB
	};

	readout_t    expected_q[$];
	int unsigned mismatch_total = 0;

	function automatic logic [7:0] glyph_of(input int n);
		return DigitGlyphs[8 * (n % 10) +: 8];
	endfunction

	function automatic readout_t predict_readout(input logic [15:0] value, input logic pt,
		input logic bat, input logic hold);
		readout_t r;
		int       v;
		int       m;
		v = int'($signed(value));
		m = (v < 0) ? -v : v;
		r.leading_one = 1'b0;
		if (v < -99) begin
			r.hundreds = GlyphBlank;
			r.tens     = GlyphL;
			r.units    = GlyphLowO;
		end else if (v < -9) begin
			r.hundreds = GlyphDash;
			r.tens     = glyph_of(m / 10);
			r.units    = glyph_of(m);
		end else if (v < 0) begin
			r.hundreds = pt ? GlyphDash : GlyphBlank;
			r.tens     = pt ? glyph_of(0) : GlyphDash;
			r.units    = glyph_of(m);
		end else if (v < 10) begin
			r.hundreds = GlyphBlank;
			r.tens     = pt ? glyph_of(0) : GlyphBlank;
			r.units    = glyph_of(m);
		end else if (v < 100) begin
			r.hundreds = GlyphBlank;
			r.tens     = glyph_of(m / 10);
			r.units    = glyph_of(m);
		end else if (v < 2000) begin
			r.leading_one = (m >= 1000);
			r.hundreds    = glyph_of(m / 100);
			r.tens        = glyph_of(m / 10);
			r.units       = glyph_of(m);
		end else begin
			r.hundreds = GlyphBlank;
			r.tens     = GlyphH;
			r.units    = GlyphI;
		end
		if (bat) r.hundreds = r.hundreds | Annunciator;
		if (pt) r.tens = r.tens | Annunciator;
		if (hold) r.units = r.units | Annunciator;
		return r;
	endfunction

	always @(posedge clk) begin : track_readouts
		readout_t want;
		readout_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(predict_readout(s_tdata[15:0], s_tdata[16], s_tdata[17],
					s_tdata[18]));
			end
			if (m_tvalid && m_tready) begin
				got.leading_one = m_tdata[0];
				got.hundreds    = m_tdata[8:1];
				got.tens        = m_tdata[16:9];
				got.units       = m_tdata[24:17];
				if (expected_q.size() == 0) begin
					$error("result transaction with no reading pending: m_tdata %0h", m_tdata);
					mismatch_total++;
				end else begin
					want = expected_q.pop_front();
					if (got.leading_one !== want.leading_one) begin
						$error("leading_one: expected %0h, actual %0h", want.leading_one,
							got.leading_one);
						mismatch_total++;
					end
					if (got.hundreds !== want.hundreds) begin
						$error("hundreds_segments: expected %02h, actual %02h", want.hundreds,
							got.hundreds);
						mismatch_total++;
					end
					if (got.tens !== want.tens) begin
						$error("tens_segments: expected %02h, actual %02h", want.tens, got.tens);
						mismatch_total++;
					end
					if (got.units !== want.units) begin
						$error("units_segments: expected %02h, actual %02h", want.units,
							got.units);
						mismatch_total++;
					end
				end
			end
		end
		pending    <= expected_q.size();
		fail_count <= mismatch_total;
	end

endmodule

/* verif/four_digit_segment_readout_top_tb.sv */
// testbench top: drives readings and result backpressure, gives the verdict
`timescale 1ns / 1ps

module four_digit_segment_readout_top_tb;

	localparam int unsigned RandomReadings = 1650;
	localparam int unsigned StallLimit     = 2000;
	localparam int unsigned DrainCycles    = 8;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [fdsr_pkg::InTdataWidth-1:0]   s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [fdsr_pkg::OutTdataWidth-1:0]  m_tdata;
	int unsigned                         pending;
	int unsigned                         fail_count;
	int unsigned                         idle_cycles = 0;
	bit                                  calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	four_digit_segment_readout_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	four_digit_segment_readout_checker readout_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [15:0] pick_value();
		int edges[7] = '{-100, -10, 0, 10, 100, 1000, 2000};
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = int'($urandom_range(0, 2120)) - 120;
			3:       v = edges[$urandom_range(0, 6)] + int'($urandom_range(0, 4)) - 2;
			4, 5:    v = int'($urandom_range(0, 198)) - 99;
			6:       v = int'($urandom_range(0, 40)) - 20;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return v[15:0];
	endfunction

	task automatic push_reading(input logic [15:0] value, input logic pt, input logic bat,
		input logic hold);
		s_tdata  <= {5'b0, hold, bat, pt, value};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic sender_gap(input int unsigned n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// no transaction on either side
	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
	end

	initial begin
		while (idle_cycles < StallLimit) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : result_backpressure
		int unsigned busy;
		int unsigned run;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			busy = pick_gap();
			run  = $urandom_range(1, 12);
			if (busy > 0) begin
				m_tready <= 1'b0;
				repeat (busy) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	initial begin : reading_source
		int          edge_values[22] = '{-32768, 32767, -100, -99, -50, -10, -9, -9, -1, -1,
			0, 0, 5, 9, 10, 99, 100, 999, 1000, 1999, 2000, -101};
		bit          edge_points[22] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0,
			1, 0, 1, 0, 1, 0, 0, 1, 0, 1, 1, 0};
		logic [15:0] v;
		logic [2:0]  marks;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 22; i++) begin
			v = edge_values[i][15:0];
			push_reading(v, edge_points[i], i[0], i[1]);
			sender_gap(pick_gap());
		end

		for (int i = 0; i < RandomReadings; i++) begin
			calm = (i >= 300 && i < 500);
			if (i == 900) begin
				s_tvalid <= 1'b0;
				wait_results_done();
			end
			v     = pick_value();
			marks = 3'($urandom_range(0, 7));
			push_reading(v, marks[0], marks[1], marks[2]);
			sender_gap(pick_gap());
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		wait_results_done();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/fdsr_pkg.sv
rtl/four_digit_segment_readout_top.sv
verif/four_digit_segment_readout_checker.sv
verif/four_digit_segment_readout_top_tb.sv
